// ===== src/alux_pkg.sv =====
// ----------------------------------------------------------------------------
// Ambient light lux package
// Shared widths, register indexes, coefficient tables and the stage payload.
// ----------------------------------------------------------------------------
package alux_pkg;

   localparam int CntW    = 16;
   localparam int ChW     = 25;   // scaled count: 16 bits times up to 2^9
   localparam int QuoW    = 11;   // ch1/ch0 in Q11, below 2^11 while ch1 < ch0
   localparam int RatW    = 11;
   localparam int LuxW    = 21;
   localparam int CoefW   = 10;
   localparam int ProdW   = ChW + CoefW;
   localparam int NumCell = QuoW; // one restoring-division bit per cell

   localparam logic [1:0] REG_ITIME   = 2'd0;
   localparam logic [1:0] REG_GAIN    = 2'd1;
   localparam logic [1:0] REG_PACKAGE = 2'd2;

   localparam logic [15:0] SCALE_T0  = 16'h7517;
   localparam logic [15:0] SCALE_T1  = 16'h0fe7;
   localparam logic [15:0] COUNT_SAT = 16'hffff;

   typedef struct packed {
      logic            valid;
      logic            clip;
      logic            pkg;
      logic [ChW-1:0]  ch0;
      logic [ChW-1:0]  ch1;
      logic [ChW:0]    rem;   // partial remainder
      logic [QuoW-1:0] quo;   // quotient bits so far
   } cell_data_type;

   function automatic logic [CoefW-1:0] brk_f(input logic pkg, input logic [2:0] i);
      logic [CoefW-1:0] v;
      case ({pkg, i})
         4'h0: v = 10'h040; 4'h1: v = 10'h080; 4'h2: v = 10'h0c0; 4'h3: v = 10'h100;
         4'h4: v = 10'h138; 4'h5: v = 10'h19a; 4'h6: v = 10'h29a;
         4'h8: v = 10'h043; 4'h9: v = 10'h085; 4'ha: v = 10'h0c8; 4'hb: v = 10'h10a;
         4'hc: v = 10'h14d; 4'hd: v = 10'h19a; 4'he: v = 10'h29a;
         default: v = 10'h3ff;
      endcase
      return v;
   endfunction

   function automatic logic [CoefW-1:0] off_f(input logic pkg, input logic [2:0] s);
      logic [CoefW-1:0] v;
      case ({pkg, s})
         4'h0: v = 10'h1f2; 4'h1: v = 10'h214; 4'h2: v = 10'h23f; 4'h3: v = 10'h270;
         4'h4: v = 10'h16f; 4'h5: v = 10'h0d2; 4'h6: v = 10'h018;
         4'h8: v = 10'h204; 4'h9: v = 10'h228; 4'ha: v = 10'h253; 4'hb: v = 10'h282;
         4'hc: v = 10'h177; 4'hd: v = 10'h101; 4'he: v = 10'h037;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [CoefW-1:0] slp_f(input logic pkg, input logic [2:0] s);
      logic [CoefW-1:0] v;
      case ({pkg, s})
         4'h0: v = 10'h1be; 4'h1: v = 10'h2d1; 4'h2: v = 10'h37b; 4'h3: v = 10'h3fe;
         4'h4: v = 10'h1fc; 4'h5: v = 10'h0fb; 4'h6: v = 10'h012;
         4'h8: v = 10'h1ad; 4'h9: v = 10'h2c1; 4'ha: v = 10'h363; 4'hb: v = 10'h3df;
         4'hc: v = 10'h1dd; 4'hd: v = 10'h127; 4'he: v = 10'h02b;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/alux_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step per cell; the payload moves on every cycle
// that the pipeline advances.
// ----------------------------------------------------------------------------
module alux_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  alux_pkg::cell_data_type d_in,
   output alux_pkg::cell_data_type d_out
);

   alux_pkg::cell_data_type data_ff, data_in;
   logic [alux_pkg::ChW+1:0] trial;

   always_comb begin
      data_in = d_in;
      trial   = {d_in.rem, 1'b0} - {2'b00, d_in.ch0};
      // Numerator bits are zero below the shifted ch1, so only the remainder shifts.
      if (!trial[alux_pkg::ChW+1]) begin
         data_in.rem = trial[alux_pkg::ChW:0];
         data_in.quo = {d_in.quo[alux_pkg::QuoW-2:0], 1'b1};
      end else begin
         data_in.rem = {d_in.rem[alux_pkg::ChW-1:0], 1'b0};
         data_in.quo = {d_in.quo[alux_pkg::QuoW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff.valid <= data_in.valid;
      end
      if (advance) begin
         data_ff.clip <= data_in.clip;
         data_ff.pkg  <= data_in.pkg;
         data_ff.ch0  <= data_in.ch0;
         data_ff.ch1  <= data_in.ch1;
         data_ff.rem  <= data_in.rem;
         data_ff.quo  <= data_in.quo;
      end
   end

   assign d_out = data_ff;

endmodule

// ===== src/ambient_light_lux_calc.sv =====
// ----------------------------------------------------------------------------
// Ambient light lux calculation
// Two-channel light sensor counts to rounded illuminance with clip status.
// ----------------------------------------------------------------------------
// Pipeline: a request transaction passes through the scale stage, 11 divider
// cells, the segment stage, the product stage and the output register, one
// register each, before its response shows on rsp_tvalid.
// Throughput: one transaction per cycle; the whole chain stalls only while
// the output register holds a response that is not taken.
// Reset: synchronous, active high; clears all valid bits and sets the
// configuration registers to their reset values: itime 2, gain 0, package 0.
module ambient_light_lux_calc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] broadband_count, [31:16] infrared_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] lux, [21] status, [23:22] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data
);

   localparam int ChW = alux_pkg::ChW;
   localparam int N   = alux_pkg::NumCell;

   // Configuration registers; always writable.
   logic [1:0] itime_ff;
   logic       gain_ff, pkg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         itime_ff <= 2'd2;
         gain_ff  <= 1'b0;
         pkg_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            alux_pkg::REG_ITIME:   itime_ff <= csr_data;
            alux_pkg::REG_GAIN:    gain_ff  <= csr_data[0];
            alux_pkg::REG_PACKAGE: pkg_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The whole chain moves together whenever the output slot is free or drained.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Scale stage: one 16x20 multiply per channel, then shift by 10.
   logic [15:0] c0, c1, scale;
   logic [19:0] scale_g;
   logic [35:0] p0, p1;
   logic        clip;
   alux_pkg::cell_data_type chain [0:N];
   alux_pkg::cell_data_type s0_ff, s0_in;

   always_comb begin
      c0 = req_tdata[15:0];
      c1 = req_tdata[31:16];
      case (itime_ff)
         2'd0:    scale = alux_pkg::SCALE_T0;
         2'd1:    scale = alux_pkg::SCALE_T1;
         default: scale = 16'd1024;
      endcase
      scale_g = gain_ff ? {4'd0, scale} : {scale, 4'd0};
      p0   = 36'(c0) * 36'(scale_g);
      p1   = 36'(c1) * 36'(scale_g);
      clip = (c1 > c0) || (c0 == alux_pkg::COUNT_SAT) || (c1 == alux_pkg::COUNT_SAT);
      s0_in.valid = req_tvalid;
      s0_in.clip  = clip;
      s0_in.pkg   = pkg_ff;
      s0_in.ch0   = p0[ChW+9:10];
      s0_in.ch1   = p1[ChW+9:10];
      // The divider starts from a remainder equal to the scaled channel 1.
      s0_in.rem   = {1'b0, p1[ChW+9:10]};
      s0_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_ff.valid <= s0_in.valid;
      end
      if (advance) begin
         s0_ff.clip <= s0_in.clip;
         s0_ff.pkg  <= s0_in.pkg;
         s0_ff.ch0  <= s0_in.ch0;
         s0_ff.ch1  <= s0_in.ch1;
         s0_ff.rem  <= s0_in.rem;
         s0_ff.quo  <= s0_in.quo;
      end
   end

   // The eleven cells form floor((ch1 << 11) / ch0). Starting the remainder at
   // ch1 is valid whenever ch1 < ch0, which also keeps the quotient below 2^11.
   // Equal channels and a zero channel 0 are resolved after the chain.
   assign chain[0] = s0_ff;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         alux_div_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .advance(advance),
            .d_in   (chain[g]),
            .d_out  (chain[g+1])
         );
      end
   endgenerate

   // Dropping the lowest quotient bit gives floor((ch1 << 10) / ch0); one more
   // rounded halving gives the ratio in Q9.
   alux_pkg::cell_data_type   dv;
   logic [alux_pkg::RatW-1:0] ratio;
   assign dv = chain[N];

   always_comb begin
      // Equal channels give a quotient of exactly 2^11, out of the cells' reach;
      // their rounded ratio is 1.0, which is 512 in Q9.
      if (dv.ch0 == '0)              ratio = '0;
      else if (dv.ch1 == dv.ch0)     ratio = 11'd512;
      else ratio = 11'((12'(dv.quo[alux_pkg::QuoW-1:1]) + 12'd1) >> 1);
   end

   // Segment stage.
   logic [2:0] seg;
   always_comb begin
      seg = 3'd7;
      for (int i = 6; i >= 0; i--) begin
         if ({1'b0, ratio} <= 12'(alux_pkg::brk_f(dv.pkg, 3'(i)))) seg = 3'(i);
      end
   end

   logic                         s1_valid_ff, s1_clip_ff;
   logic [ChW-1:0]               s1_ch0_ff, s1_ch1_ff;
   logic [alux_pkg::CoefW-1:0]   s1_off_ff, s1_slp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= dv.valid;
      end
      if (advance) begin
         s1_clip_ff <= dv.clip;
         s1_ch0_ff  <= dv.ch0;
         s1_ch1_ff  <= dv.ch1;
         s1_off_ff  <= alux_pkg::off_f(dv.pkg, seg);
         s1_slp_ff  <= alux_pkg::slp_f(dv.pkg, seg);
      end
   end

   // Product stage.
   logic                       s2_valid_ff, s2_clip_ff;
   logic [alux_pkg::ProdW-1:0] s2_pos_ff, s2_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_clip_ff <= s1_clip_ff;
         s2_pos_ff  <= alux_pkg::ProdW'(s1_ch0_ff) * alux_pkg::ProdW'(s1_off_ff);
         s2_neg_ff  <= alux_pkg::ProdW'(s1_ch1_ff) * alux_pkg::ProdW'(s1_slp_ff);
      end
   end

   // Difference, rounding, clamp, zero lux on clip and output register.
   logic [alux_pkg::ProdW-1:0] diff, rnd;
   logic [alux_pkg::LuxW-1:0]  lux;
   logic                       rsp_valid_ff;
   logic [alux_pkg::LuxW:0]    rsp_data_ff;

   always_comb begin
      diff = (s2_pos_ff > s2_neg_ff) ? (s2_pos_ff - s2_neg_ff) : '0;
      rnd  = (diff + alux_pkg::ProdW'(14'd8192)) >> 14;
      lux  = (rnd > alux_pkg::ProdW'(21'h1fffff)) ? 21'h1fffff : rnd[alux_pkg::LuxW-1:0];
      if (s2_clip_ff) lux = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         rsp_data_ff <= {s2_clip_ff, lux};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

// ===== src/alux_checker.sv =====
// ----------------------------------------------------------------------------
// Lux calculation checker
// Port-level properties of the lux block, bound to its top level.
// ----------------------------------------------------------------------------
module alux_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A clipped response always carries zero lux.
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[20:0] == '0)
      else $error("clipped response with nonzero lux");

   // Padding bits stay zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:22] == 2'b00)
      else $error("response padding nonzero");

   // A stalled response holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Input is ready whenever the output slot is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind ambient_light_lux_calc alux_checker u_alux_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
